// File: design/tst_pkg.sv
// Shared types and constants for the timed session table.
// Depends on nothing; every other design file imports it.
`default_nettype none

package tst_pkg;

  localparam int          TABLE_ENTRIES_DEFAULT = 8;
  localparam int          TIME_W                = 48;
  localparam int          LIFE_W                = 32;
  localparam int          SLOT_W                = 3;
  localparam int          COUNT_W               = 4;
  localparam logic [31:0] LIFETIME_RESET        = 32'd43200000;
  localparam logic [3:0]  COUNT_MAX             = 4'hF;

  typedef enum logic [1:0] {
    ACT_VALIDATE = 2'd0,
    ACT_CREATE   = 2'd1,
    ACT_DROP     = 2'd2,
    ACT_COUNT    = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [TIME_W-1:0]   now_time;
    logic [31:0]         client_addr;
    logic                token_present;
    logic [63:0]         token_high;
    logic [63:0]         token_low;
    logic [63:0]         agent_high;
    logic [63:0]         agent_low;
  } req_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  live_count;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [31:0]         addr;
    logic [63:0]         token_high;
    logic [63:0]         token_low;
    logic [63:0]         agent_high;
    logic [63:0]         agent_low;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic write;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/tst_req_if.sv
// Request channel of the timed session table: valid, ready and payload.
// Depends on tst_pkg for the payload type.
`default_nettype none

interface tst_req_if import tst_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/tst_rsp_if.sv
// Response channel of the timed session table: valid, ready and payload.
// Depends on tst_pkg for the payload type.
`default_nettype none

interface tst_rsp_if import tst_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/tst_ctrl.sv
// Sequencer of the timed session table: accept, scan, write back, respond.
// Depends on tst_pkg for the command and status structs.
`default_nettype none

module tst_ctrl import tst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tst_dpath.sv
// Datapath of the timed session table: entry memory, valid bits, scan logic,
// lifetime register and response register. Depends on tst_pkg.
`default_nettype none

module tst_dpath import tst_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [LIFE_W-1:0] cfg_write_data,
  input  req_t              req_payload,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output rsp_t              rsp_payload,
  input  dp_cmd_t           cmd,
  output dp_status_t        status
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

  entry_t              mem [TABLE_ENTRIES];
  entry_t              rd_data;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] valid_next;
  req_t                req_q;
  logic [LIFE_W-1:0]   lifetime;

  logic [CW-1:0]       rd_cnt;
  logic                rd_more;
  logic                eval_vld;
  logic [IW-1:0]       eval_idx;
  logic                hit;
  logic                hit_next;
  logic                found;
  logic                found_next;
  logic [IW-1:0]       sel;
  logic [IW-1:0]       sel_next;
  logic [TIME_W:0]     oldest;
  logic [TIME_W:0]     oldest_next;
  logic [COUNT_W-1:0]  live_cnt;
  logic [COUNT_W-1:0]  live_next;

  logic                cur_v;
  logic                expired;
  logic                cur_live;
  logic                full_match;
  logic                tok_match;
  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   exp_new;
  logic                we;
  entry_t              wdata;
  logic                granted;
  logic [IW+SLOT_W-1:0] sel_wide;

  assign rd_more  = (rd_cnt != LAST_CNT);
  assign cur_v    = valid[eval_idx];
  assign expired  = (rd_data.expiry <= req_q.now_time);
  assign cur_live = cur_v && !expired;
  assign tok_match = (rd_data.token_high == req_q.token_high) &&
                     (rd_data.token_low  == req_q.token_low);
  assign full_match = tok_match &&
                      (rd_data.addr       == req_q.client_addr) &&
                      (rd_data.agent_high == req_q.agent_high) &&
                      (rd_data.agent_low  == req_q.agent_low);

  assign exp_sum = {1'b0, req_q.now_time} + (TIME_W + 1)'(lifetime);
  assign exp_new = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

  assign we = cmd.write && (((req_q.action == ACT_VALIDATE) && hit) ||
                            (req_q.action == ACT_CREATE));
  assign wdata = '{expiry:     exp_new,
                   addr:       req_q.client_addr,
                   token_high: req_q.token_high,
                   token_low:  req_q.token_low,
                   agent_high: req_q.agent_high,
                   agent_low:  req_q.agent_low};

  assign granted  = ((req_q.action == ACT_VALIDATE) && hit) ||
                    (req_q.action == ACT_CREATE);
  assign sel_wide = {{SLOT_W{1'b0}}, sel};

  assign status.scan_done = (rd_cnt == LAST_CNT) && eval_vld;
  assign status.out_busy  = rsp_valid && !rsp_ready;

  always_comb begin
    valid_next  = valid;
    hit_next    = hit;
    found_next  = found;
    sel_next    = sel;
    oldest_next = oldest;
    live_next   = live_cnt;
    if (cmd.scan && eval_vld) begin
      unique case (req_q.action)
        ACT_VALIDATE: begin
          if (req_q.token_present && !hit) begin
            if (cur_v && expired) begin
              valid_next[eval_idx] = 1'b0;
            end else if (cur_live && full_match) begin
              hit_next = 1'b1;
              sel_next = eval_idx;
            end
          end
        end
        ACT_CREATE: begin
          if (!found) begin
            if (!cur_live) begin
              found_next = 1'b1;
              sel_next   = eval_idx;
            end else if ({1'b0, rd_data.expiry} < oldest) begin
              oldest_next = {1'b0, rd_data.expiry};
              sel_next    = eval_idx;
            end
          end
        end
        ACT_DROP: begin
          if (req_q.token_present && cur_v && tok_match) begin
            valid_next[eval_idx] = 1'b0;
          end
        end
        ACT_COUNT: begin
          if (cur_live && (live_cnt != COUNT_MAX)) begin
            live_next = live_cnt + COUNT_W'(1);
          end
        end
      endcase
    end
    if (cmd.write && (req_q.action == ACT_CREATE)) begin
      valid_next[sel] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      rd_data <= mem[rd_cnt[IW-1:0]];
    end
    if (we) begin
      mem[sel] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q  <= req_payload;
      oldest <= {1'b1, {TIME_W{1'b0}}};
    end else begin
      oldest <= oldest_next;
    end
    sel <= sel_next;
    if (cmd.scan && rd_more) begin
      eval_idx <= rd_cnt[IW-1:0];
    end
    if (cmd.load_out) begin
      rsp_payload.granted    <= granted;
      rsp_payload.slot_index <= granted ? sel_wide[SLOT_W-1:0] : '0;
      rsp_payload.live_count <= (req_q.action == ACT_COUNT) ? live_cnt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime  <= LIFETIME_RESET;
      valid     <= '0;
      rd_cnt    <= '0;
      eval_vld  <= 1'b0;
      hit       <= 1'b0;
      found     <= 1'b0;
      live_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        lifetime <= cfg_write_data;
      end
      valid <= valid_next;
      if (cmd.start) begin
        rd_cnt   <= '0;
        eval_vld <= 1'b0;
        hit      <= 1'b0;
        found    <= 1'b0;
        live_cnt <= '0;
      end else begin
        hit      <= hit_next;
        found    <= found_next;
        live_cnt <= live_next;
        if (cmd.scan) begin
          rd_cnt   <= rd_cnt + CW'(rd_more);
          eval_vld <= rd_more;
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_hit_only_validate: assert property (@(posedge clk) disable iff (rst)
    hit |-> (req_q.action == ACT_VALIDATE))
    else $error("hit flag set outside validate");

  a_create_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && (req_q.action == ACT_CREATE)) |=> valid[$past(sel)])
    else $error("created entry not marked valid");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= LAST_CNT)
    else $error("scan counter beyond table");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(live_cnt) <= TABLE_ENTRIES) || (live_cnt == COUNT_MAX))
    else $error("live count exceeds table size");

  a_no_scan_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan && cmd.write))
    else $error("scan and write-back overlap");

endmodule

`default_nettype wire

// File: design/timed_session_table_unit.sv
// Top level of the timed session table: controller plus datapath.
// Depends on tst_pkg, tst_req_if, tst_rsp_if, tst_ctrl and tst_dpath.
//
//   port            dir   handshake          content
//   req             in    valid / ready      action, time, address, token, agent
//   rsp             out   valid / ready      granted, slot_index, live_count
//   cfg_write_*     in    write enable only  lifetime_ticks
//
// Each request runs from acceptance to a loaded response in these steps: one
// read of the entry memory per cycle, with the evaluation of each entry one
// register behind, then one write-back state and one load state.
// One request is in flight at a time; the next is taken as soon as the
// response is loaded, even while that response still waits in its register.
// A stalled response holds the sequencer before loading the next one.
// Reset clears the valid bits at once; no clearing pass is needed.
`default_nettype none

module timed_session_table_unit import tst_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [LIFE_W-1:0] cfg_write_data,
  tst_req_if.sink           req,
  tst_rsp_if.source         rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tst_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_payload    (req.payload),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_payload    (rsp.payload),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire
